/* hw/rtl/smbr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbr_pkg
// Types and constants shared by the softmax backward row block.
// ----------------------------------------------------------------------------
package smbr_pkg;

   localparam int DATA_W     = 32;
   localparam int ACC_W      = 64;
   localparam int FRAC_BITS  = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr above the byte offset
   localparam logic REG_BETA_SCALE = 1'b0;

   typedef struct packed {
      logic signed [DATA_W-1:0] upstream_grad;
      logic signed [DATA_W-1:0] softmax_value;
      logic signed [DATA_W-1:0] old_dest;
      logic                     row_end;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_dest;
      logic                     last_of_row;
      logic                     overflow_flag;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] grad;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] dest;
   } mem_word_type;

   typedef struct packed {
      logic valid;
      logic last;
   } emit_ctrl_type;

endpackage
`default_nettype wire

/* hw/rtl/softmax_backward_row_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// softmax_backward_row_top
// Softmax backward pass over one row: stores the row, accumulates the
// gradient-output dot product and emits one saturated result per stored element.
// ----------------------------------------------------------------------------
// throughput: one element accepted per cycle while a row is collected, then
//   one result per cycle while the result port is not stalled; the row
//   memory is written during collection and read during emission
// reset: control state, dot product and beta clear; the row memory is not
//   cleared, entries are always written before they are read
module softmax_backward_row_top #(
   parameter int MAX_COLS   = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire smbr_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output smbr_pkg::rsp_type                    rsp_data,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [smbr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [smbr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [smbr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import smbr_pkg::*;

   localparam int CNT_W  = $clog2(MAX_COLS + 1);
   localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   localparam logic [1:0] S_COLLECT = 2'd0;
   localparam logic [1:0] S_WAIT    = 2'd1;
   localparam logic [1:0] S_EMIT    = 2'd2;
   localparam logic [1:0] S_FLUSH   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             ovf_ff, ovf_in;

   logic signed [DATA_W-1:0] beta_scale;
   logic signed [ACC_W-1:0]  dot;
   logic                     acc_busy;
   logic                     pipe_busy;
   logic                     accept;
   logic                     store;
   logic                     adv;
   logic                     dot_clear;
   emit_ctrl_type            issue;
   mem_word_type             wr_word;
   mem_word_type             rd_word;

   assign req_stall = (state_ff != S_COLLECT);
   assign accept    = req_valid && !req_stall;
   assign store     = accept && (count_ff < CNT_W'(MAX_COLS));
   assign adv       = !rsp_valid || !rsp_stall;

   assign wr_word.grad  = req_data.upstream_grad;
   assign wr_word.value = req_data.softmax_value;
   assign wr_word.dest  = req_data.old_dest;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      ovf_in      = ovf_ff;
      dot_clear   = 1'b0;
      issue.valid = 1'b0;
      issue.last  = (rd_idx_ff == count_ff - CNT_W'(1));
      unique case (state_ff)
         S_COLLECT: begin
            if (store) begin
               count_in = count_ff + CNT_W'(1);
            end else if (accept) begin
               ovf_in = 1'b1;
            end
            if (accept && req_data.row_end) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!acc_busy) begin
               rd_idx_in = '0;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            if (adv) begin
               issue.valid = 1'b1;
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               if (issue.last) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!pipe_busy) begin
               count_in  = '0;
               ovf_in    = 1'b0;
               dot_clear = 1'b1;
               state_in  = S_COLLECT;
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_COLLECT;
         count_ff  <= '0;
         rd_idx_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         ovf_ff    <= ovf_in;
      end
   end

   smbr_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .beta_scale (beta_scale)
   );

   smbr_row_mem #(
      .DEPTH  (MAX_COLS),
      .ADDR_W (ADDR_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_word),
      .rd_en   (issue.valid),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_word)
   );

   smbr_dot_acc u_dot_acc (
      .clock (clock),
      .reset (reset),
      .take  (store),
      .grad  (req_data.upstream_grad),
      .value (req_data.softmax_value),
      .clear (dot_clear),
      .dot   (dot),
      .busy  (acc_busy)
   );

   smbr_emit_pipe #(
      .VALUE_BITS (VALUE_BITS)
   ) u_emit_pipe (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .issue      (issue),
      .rd_word    (rd_word),
      .dot        (dot),
      .beta_scale (beta_scale),
      .row_ovf    (ovf_ff),
      .busy       (pipe_busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

/* hw/rtl/smbr_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbr_csr
// Register port holding the beta weight applied to the old destination.
// ----------------------------------------------------------------------------
module smbr_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [smbr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [smbr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [smbr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready,
   output logic signed [smbr_pkg::DATA_W-1:0]       beta_scale
);
   import smbr_pkg::*;

   logic signed [DATA_W-1:0] beta_ff;
   logic signed [DATA_W-1:0] beta_in;
   logic                     reg_sel;
   logic                     wr_xfer;

   assign reg_sel = (paddr[CSR_ADDR_W-1] == REG_BETA_SCALE);
   assign wr_xfer = psel && penable && pwrite && pready;

   always_comb begin
      beta_in = beta_ff;
      if (wr_xfer && reg_sel) begin
         beta_in = $signed(pwdata[DATA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= '0;
      end else begin
         beta_ff <= beta_in;
      end
   end

   assign pready     = 1'b1;
   assign prdata     = reg_sel ? CSR_DATA_W'(beta_ff) : '0;
   assign beta_scale = beta_ff;

endmodule
`default_nettype wire

/* hw/rtl/smbr_row_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbr_row_mem
// Row store: gradient, softmax value and old destination per element,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module smbr_row_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire smbr_pkg::mem_word_type wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output smbr_pkg::mem_word_type      rd_data
);
   import smbr_pkg::*;

   mem_word_type row_mem_ff [DEPTH];
   mem_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/smbr_dot_acc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbr_dot_acc
// Running dot product of gradient and softmax value over one row:
// registered multiply, then floor to Q16.16 and accumulate.
// ----------------------------------------------------------------------------
module smbr_dot_acc (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               take,
   input  wire logic signed [smbr_pkg::DATA_W-1:0] grad,
   input  wire logic signed [smbr_pkg::DATA_W-1:0] value,
   input  wire logic                               clear,
   output logic signed [smbr_pkg::ACC_W-1:0]       dot,
   output logic                                    busy
);
   import smbr_pkg::*;

   logic                     mul_valid_ff;
   logic signed [DATA_W-1:0] grad_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]  dot_ff;
   logic signed [ACC_W-1:0]  dot_in;

   always_comb begin
      dot_in = dot_ff;
      if (clear) begin
         dot_in = '0;
      end else if (prod_valid_ff) begin
         dot_in = dot_ff + (prod_ff >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         dot_ff        <= '0;
      end else begin
         mul_valid_ff  <= take;
         prod_valid_ff <= mul_valid_ff;
         dot_ff        <= dot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         grad_ff  <= grad;
         value_ff <= value;
      end
      if (mul_valid_ff) begin
         prod_ff <= ACC_W'(grad_ff) * ACC_W'(value_ff);
      end
   end

   assign dot  = dot_ff;
   assign busy = mul_valid_ff || prod_valid_ff;

endmodule
`default_nettype wire

/* hw/rtl/smbr_emit_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbr_emit_pipe
// Result pipeline: saturated difference, two products, floor, sum and
// saturate, then the output register. Every stage advances together.
// ----------------------------------------------------------------------------
module smbr_emit_pipe #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               adv,
   input  wire smbr_pkg::emit_ctrl_type            issue,
   input  wire smbr_pkg::mem_word_type             rd_word,
   input  wire logic signed [smbr_pkg::ACC_W-1:0]  dot,
   input  wire logic signed [smbr_pkg::DATA_W-1:0] beta_scale,
   input  wire logic                               row_ovf,
   output logic                                    busy,
   output logic                                    rsp_valid,
   output smbr_pkg::rsp_type                       rsp_data
);
   import smbr_pkg::*;

   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (VALUE_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   logic                     v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic                     last1_ff, last2_ff, last3_ff;
   logic                     flag2_ff, flag3_ff;
   logic signed [DATA_W-1:0] diff2_ff, value2_ff, dest2_ff;
   logic signed [ACC_W-1:0]  term3_ff, bterm3_ff;
   rsp_type                  out_ff;
   rsp_type                  out_in;

   logic signed [ACC_W-1:0]  diff_full;
   logic signed [DATA_W-1:0] diff_sat;
   logic                     diff_flag;
   logic signed [ACC_W-1:0]  sum_full;

   // stage one: gradient minus dot, saturated
   always_comb begin
      diff_full = ACC_W'(rd_word.grad) - dot;
      diff_flag = 1'b0;
      diff_sat  = diff_full[DATA_W-1:0];
      if (diff_full > SAT_HI) begin
         diff_flag = 1'b1;
         diff_sat  = SAT_HI[DATA_W-1:0];
      end else if (diff_full < SAT_LO) begin
         diff_flag = 1'b1;
         diff_sat  = SAT_LO[DATA_W-1:0];
      end
   end

   // stage three: floor both products, add, saturate
   always_comb begin
      sum_full             = (term3_ff >>> FRAC_BITS) + (bterm3_ff >>> FRAC_BITS);
      out_in.last_of_row   = last3_ff;
      out_in.overflow_flag = flag3_ff;
      out_in.new_dest      = sum_full[DATA_W-1:0];
      if (sum_full > SAT_HI) begin
         out_in.overflow_flag = 1'b1;
         out_in.new_dest      = SAT_HI[DATA_W-1:0];
      end else if (sum_full < SAT_LO) begin
         out_in.overflow_flag = 1'b1;
         out_in.new_dest      = SAT_LO[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= issue.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last1_ff  <= issue.last;
         last2_ff  <= last1_ff;
         flag2_ff  <= row_ovf || diff_flag;
         diff2_ff  <= diff_sat;
         value2_ff <= rd_word.value;
         dest2_ff  <= rd_word.dest;
         last3_ff  <= last2_ff;
         flag3_ff  <= flag2_ff;
         term3_ff  <= ACC_W'(value2_ff) * ACC_W'(diff2_ff);
         bterm3_ff <= ACC_W'(beta_scale) * ACC_W'(dest2_ff);
         out_ff    <= out_in;
      end
   end

   assign busy      = v1_ff || v2_ff || v3_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

/* tb/softmax_backward_row_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_backward_row_checker
// Watches the element, result and register ports of the softmax backward row
// block, keeps its own copy of the row and beta, predicts every result of a
// row when its row-end transfer is seen and compares the results in order.
// ----------------------------------------------------------------------------
module softmax_backward_row_checker #(
   parameter int MAX_COLS   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  smbr_pkg::req_type                    req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  smbr_pkg::rsp_type                    rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic      [smbr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic      [smbr_pkg::CSR_DATA_W-1:0] pwdata,
   output int                                   mismatch_count,
   output int                                   results_pending
);
   import smbr_pkg::*;

   localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
   localparam longint VALUE_MIN = -VALUE_MAX - 1;

   longint  beta_scale;
   longint  row_grad  [MAX_COLS];
   longint  row_value [MAX_COLS];
   longint  row_dest  [MAX_COLS];
   int      row_length;
   longint  row_dot;
   bit      row_too_long;
   rsp_type queued_dests[$];

   // q32.32 product back to q16.16, rounding toward minus infinity
   function automatic longint floor_q16(longint x);
      return x >>> FRAC_BITS;
   endfunction

   function automatic longint clamp_value(longint x, inout bit hit);
      if (x > VALUE_MAX) begin
         hit = 1'b1;
         return VALUE_MAX;
      end
      if (x < VALUE_MIN) begin
         hit = 1'b1;
         return VALUE_MIN;
      end
      return x;
   endfunction

   function automatic void emit_row_results();
      longint  diff;
      longint  term;
      longint  scaled;
      longint  total;
      bit      hit;
      rsp_type want;
      for (int k = 0; k < row_length; k++) begin
         hit = row_too_long;
         diff = clamp_value(row_grad[k] - row_dot, hit);
         term = floor_q16(row_value[k] * diff);
         scaled = floor_q16(beta_scale * row_dest[k]);
         total = clamp_value(term + scaled, hit);
         want.new_dest = total[DATA_W-1:0];
         want.last_of_row = (k == row_length - 1);
         want.overflow_flag = hit;
         queued_dests.push_back(want);
      end
      row_length = 0;
      row_dot = 0;
      row_too_long = 1'b0;
   endfunction

   function automatic void take_element(req_type item);
      if (row_length < MAX_COLS) begin
         row_grad[row_length] = longint'($signed(item.upstream_grad));
         row_value[row_length] = longint'($signed(item.softmax_value));
         row_dest[row_length] = longint'($signed(item.old_dest));
         row_dot += floor_q16(row_grad[row_length] * row_value[row_length]);
         row_length++;
      end else begin
         row_too_long = 1'b1;
      end
      if (item.row_end) begin
         emit_row_results();
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (queued_dests.size() == 0) begin
         mismatch_count++;
         $display("%0t: result transfer with none expected, got %h", $time, got);
      end else begin
         want = queued_dests.pop_front();
         if (got.new_dest !== want.new_dest) begin
            mismatch_count++;
            $display("%0t: new_dest expected %h got %h", $time, want.new_dest, got.new_dest);
         end
         if (got.last_of_row !== want.last_of_row) begin
            mismatch_count++;
            $display("%0t: last_of_row expected %b got %b", $time,
                     want.last_of_row, got.last_of_row);
         end
         if (got.overflow_flag !== want.overflow_flag) begin
            mismatch_count++;
            $display("%0t: overflow_flag expected %b got %b", $time,
                     want.overflow_flag, got.overflow_flag);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         beta_scale = 0;
         row_length = 0;
         row_dot = 0;
         row_too_long = 1'b0;
         queued_dests.delete();
      end else begin
         if (psel && penable && pwrite && pready
             && paddr[CSR_ADDR_W-1:2] == REG_BETA_SCALE) begin
            beta_scale = longint'($signed(pwdata));
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
         if (req_valid && !req_stall) begin
            take_element(req_data);
         end
      end
      results_pending = queued_dests.size();
   end

endmodule

/* tb/softmax_backward_row_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_backward_row_top_tb
// Drives rows of gradient, softmax and old destination elements into the
// softmax backward row block under several beta settings, with random gaps
// and result stalls, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module softmax_backward_row_top_tb;
   import smbr_pkg::*;

   localparam int   MAX_COLS        = 64;
   localparam int   VALUE_BITS      = 32;
   localparam int   CYCLE_LIMIT     = 200000;
   localparam int   SETTLE_CYCLES   = 24;
   localparam int   ITEMS_PER_PHASE = 60;
   localparam int   GRAD_SPAN       = 1 << 18;
   localparam int   ONE_Q16         = 1 << 16;
   localparam logic UNMAPPED_REG    = ~REG_BETA_SCALE;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    results_pending;
   int                    cycle_count = 0;
   int                    items_sent = 0;
   bit                    calm = 1'b0;

   softmax_backward_row_top #(
      .MAX_COLS   (MAX_COLS),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   softmax_backward_row_checker #(
      .MAX_COLS   (MAX_COLS),
      .VALUE_BITS (VALUE_BITS)
   ) result_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL softmax_backward_row_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 15);
   end

   // mostly small q16.16 values, some raw words and extremes
   function automatic logic [31:0] random_fixed(int unsigned span);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         return $urandom();
      end
      if (roll < 26) begin
         case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic int pick_row_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return $urandom_range(1, 8);
      end
      if (roll < 85) begin
         return $urandom_range(9, MAX_COLS - 1);
      end
      if (roll < 92) begin
         return MAX_COLS;
      end
      return $urandom_range(MAX_COLS + 1, MAX_COLS + 6);
   endfunction

   task automatic send_element(logic [31:0] grad, logic [31:0] value,
                               logic [31:0] dest, logic last);
      req_type item;
      bit      stalled;
      item.upstream_grad = grad;
      item.softmax_value = value;
      item.old_dest = dest;
      item.row_end = last;
      while (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      items_sent++;
   endtask

   task automatic send_row(int length);
      for (int i = 0; i < length; i++) begin
         send_element(random_fixed(GRAD_SPAN), random_fixed(ONE_Q16),
                      random_fixed(GRAD_SPAN), i == length - 1);
      end
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      bit ready;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = pready;
         @(posedge clock);
      end while (!ready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // all rows answered, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          phase_start;
      logic [31:0] beta;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // beta at its reset value, saturating differences and a few rows
      send_element(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
      send_element(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      send_element(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_element(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      send_element(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 1'b0);
      send_element(32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 1'b0);
      send_element(32'hffff_c000, 32'h0000_4000, 32'hffff_0000, 1'b1);
      send_element(32'h0000_0100, 32'h8000_0000, 32'h0000_0000, 1'b0);
      send_element(32'hfff0_0000, 32'h7fff_ffff, 32'h1234_5678, 1'b0);
      send_element(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0000, 1'b0);
      send_element(32'haaaa_aaaa, 32'h5555_5555, 32'h7fff_ffff, 1'b1);
      settle();

      // beta of one, plus a write to an unmapped register that must be ignored
      write_csr({REG_BETA_SCALE, 2'b00}, 32'h0001_0000);
      write_csr({UNMAPPED_REG, 2'b00}, $urandom());
      send_element(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 1'b0);
      send_element(32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 1'b0);
      send_element(32'hffff_c000, 32'h0000_4000, 32'hffff_0000, 1'b1);
      send_element(32'h0000_1000, 32'h0000_2000, 32'h7fff_ffff, 1'b0);
      send_element(32'h0000_3000, 32'h0000_1000, 32'h8000_0000, 1'b1);
      settle();

      write_csr({REG_BETA_SCALE, 2'b00}, 32'h7fff_ffff);
      send_element(32'h0000_1000, 32'h0000_2000, 32'h7fff_ffff, 1'b0);
      send_element(32'h0000_3000, 32'h0000_1000, 32'h8000_0000, 1'b1);
      send_element(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1);
      settle();

      write_csr({REG_BETA_SCALE, 2'b00}, 32'h8000_0000);
      send_element(32'h0000_1000, 32'h0000_2000, 32'h7fff_ffff, 1'b0);
      send_element(32'h0000_3000, 32'h0000_1000, 32'h8000_0000, 1'b1);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: beta = $urandom();
            1: beta = $urandom_range(0, 4 * ONE_Q16) - 2 * ONE_Q16;
            2: beta = 32'hffff_0000;
            default: beta = 32'h0000_8000;
         endcase
         write_csr({REG_BETA_SCALE, 2'b00}, beta);
         calm = (phase == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            send_row(pick_row_length());
         end
         settle();
      end
      calm = 1'b0;

      if (mismatch_count == 0 && results_pending == 0) begin
         $display("PASS softmax_backward_row_top");
      end else begin
         $display("FAIL softmax_backward_row_top");
      end
      $finish;
   end

endmodule
